[rtl/core/rrpc_pkg.sv]
// Package for the relative rotation P controller: angle widths, Q4.12 constants,
// configuration register indexes and the single-wrap helper.
// No dependencies.
package rrpc_pkg;

  // Width of the stored heading registers; they wrap at this width.
  localparam int ANGLE_WIDTH = 16;
  localparam int FRAC_BITS   = 12;

  // Field widths
  localparam int YAW_W   = 15;
  localparam int GAIN_W  = 15;
  localparam int THR_W   = 14;
  localparam int SPEED_W = 16;
  localparam int MADE_W  = 15;

  // Working width: holds sums of a heading and a 15 bit angle plus one 2*pi step.
  localparam int CALC_W = ((ANGLE_WIDTH > 17) ? ANGLE_WIDTH : 17) + 2;
  localparam int PROD_W = CALC_W + GAIN_W + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P           = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ARRIVE_THRESHOLD = 1'd1;
  localparam logic [GAIN_W-1:0] GAIN_P_RESET           = 15'd2048;
  localparam logic [THR_W-1:0]  ARRIVE_THRESHOLD_RESET = 14'd819;

  localparam logic signed [CALC_W-1:0] PI_Q     = CALC_W'(12868);
  localparam logic signed [CALC_W-1:0] TWO_PI_Q = CALC_W'(25736);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] SPEED_MAX  = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SPEED_MIN  = PROD_W'(-32768);
  localparam logic signed [CALC_W-1:0] MADE_MAX   = CALC_W'(16383);
  localparam logic signed [CALC_W-1:0] MADE_MIN   = CALC_W'(-16384);

  // Fold an angle into [-pi, pi] with at most one 2*pi step.
  function automatic logic signed [CALC_W-1:0] wrap_once(input logic signed [CALC_W-1:0] a);
    logic signed [CALC_W-1:0] r;
    r = a;
    if (a > PI_Q) begin
      r = a - TWO_PI_Q;
    end else if (a < -PI_Q) begin
      r = a + TWO_PI_Q;
    end
    return r;
  endfunction

endpackage

[rtl/core/relative_rotation_p_controller_top.sv]
// Relative rotation proportional heading controller, top level.
// Uses rrpc_pkg for widths, constants and the angle wrap function.
//
// channel | ports                                           | direction
// --------+-------------------------------------------------+----------
// in      | in_valid, in_stall, in_mode, in_rotation_request, in_yaw | sink
// out     | out_valid, out_stall, out_speed_command, out_done_res,
//         | out_rotation_made                               | source
// cfg     | cfg_wr_en, cfg_addr, cfg_wdata                  | sink
//
// One beat per cycle while out_stall is low: a beat is held in the input
// register, the heading error, gain multiply and saturation run on it, and
// a yaw beat (in_mode 1) in a turn puts its result in the output register.
// Reset (synchronous, rst_n low) clears both stages, the turn state and loads
// the register defaults. A stalled output holds the input register, which then
// raises in_stall; a new beat still enters whenever the output register drains.
module relative_rotation_p_controller_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [rrpc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [rrpc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic signed [rrpc_pkg::YAW_W-1:0]      in_rotation_request,
  input  logic signed [rrpc_pkg::YAW_W-1:0]      in_yaw,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rrpc_pkg::SPEED_W-1:0]    out_speed_command,
  output logic                                   out_done_res,
  output logic signed [rrpc_pkg::MADE_W-1:0]     out_rotation_made
);

  localparam int AW = rrpc_pkg::ANGLE_WIDTH;
  localparam int CW = rrpc_pkg::CALC_W;
  localparam int PW = rrpc_pkg::PROD_W;

  // Configuration
  logic [rrpc_pkg::GAIN_W-1:0] gain_p_r;
  logic [rrpc_pkg::THR_W-1:0]  arrive_thr_r;

  // Input register
  logic                               s1_valid_r;
  logic                               s1_mode_r;
  logic signed [rrpc_pkg::YAW_W-1:0]  s1_rot_r;
  logic signed [rrpc_pkg::YAW_W-1:0]  s1_yaw_r;

  // Turn state
  logic                 pending_r, pending_nxt;
  logic signed [AW-1:0] pend_rot_r, pend_rot_nxt;
  logic                 turning_r, turning_nxt;
  logic signed [AW-1:0] target_r, target_nxt;
  logic signed [AW-1:0] start_r, start_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [rrpc_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic                              done_r, done_nxt;
  logic signed [rrpc_pkg::MADE_W-1:0]  made_r, made_nxt;

  logic advance;
  logic in_accept;

  logic signed [CW-1:0] yaw_c;
  logic signed [CW-1:0] new_target_c;
  logic signed [CW-1:0] target_c;
  logic signed [CW-1:0] err_c;
  logic signed [CW-1:0] mag_c;
  logic signed [CW-1:0] made_c;
  logic signed [PW-1:0] prod_c;
  logic signed [PW-1:0] scaled_c;
  logic                 active_c;
  logic                 far_c;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    yaw_c        = CW'(s1_yaw_r);
    new_target_c = rrpc_pkg::wrap_once(yaw_c + CW'(pend_rot_r));
    // A pending request restarts the turn from this yaw
    target_c     = pending_r ? CW'(AW'(new_target_c)) : CW'(target_r);
    active_c     = pending_r || turning_r;
    err_c        = rrpc_pkg::wrap_once(target_c - yaw_c);
    mag_c        = err_c[CW-1] ? -err_c : err_c;
    far_c        = mag_c > CW'({1'b0, arrive_thr_r});
    prod_c       = PW'(signed'({1'b0, gain_p_r})) * PW'(err_c);
    scaled_c     = (prod_c + rrpc_pkg::ROUND_HALF) >>> rrpc_pkg::FRAC_BITS;
    made_c       = rrpc_pkg::wrap_once(yaw_c - CW'(pending_r ? AW'(s1_yaw_r) : start_r));

    pending_nxt   = pending_r;
    pend_rot_nxt  = pend_rot_r;
    turning_nxt   = turning_r;
    target_nxt    = target_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r;
    speed_nxt     = speed_r;
    done_nxt      = done_r;
    made_nxt      = made_r;

    if (advance) begin
      out_valid_nxt = 1'b0;
      if (s1_valid_r) begin
        if (!s1_mode_r) begin
          pend_rot_nxt = AW'(s1_rot_r);
          pending_nxt  = 1'b1;
        end else begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            start_nxt   = AW'(s1_yaw_r);
            target_nxt  = AW'(new_target_c);
            turning_nxt = 1'b1;
          end
          if (active_c) begin
            out_valid_nxt = 1'b1;
            if (far_c) begin
              if (scaled_c > rrpc_pkg::SPEED_MAX) begin
                speed_nxt = rrpc_pkg::SPEED_W'(rrpc_pkg::SPEED_MAX);
              end else if (scaled_c < rrpc_pkg::SPEED_MIN) begin
                speed_nxt = rrpc_pkg::SPEED_W'(rrpc_pkg::SPEED_MIN);
              end else begin
                speed_nxt = rrpc_pkg::SPEED_W'(scaled_c);
              end
              done_nxt = 1'b0;
              made_nxt = '0;
            end else begin
              speed_nxt   = '0;
              done_nxt    = 1'b1;
              turning_nxt = 1'b0;
              if (made_c > rrpc_pkg::MADE_MAX) begin
                made_nxt = rrpc_pkg::MADE_W'(rrpc_pkg::MADE_MAX);
              end else if (made_c < rrpc_pkg::MADE_MIN) begin
                made_nxt = rrpc_pkg::MADE_W'(rrpc_pkg::MADE_MIN);
              end else begin
                made_nxt = rrpc_pkg::MADE_W'(made_c);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r     <= rrpc_pkg::GAIN_P_RESET;
      arrive_thr_r <= rrpc_pkg::ARRIVE_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rrpc_pkg::CFG_GAIN_P: begin
          gain_p_r <= cfg_wdata[rrpc_pkg::GAIN_W-1:0];
        end
        rrpc_pkg::CFG_ARRIVE_THRESHOLD: begin
          arrive_thr_r <= cfg_wdata[rrpc_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: load a new beat, drop the old one once it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r <= in_mode;
      s1_rot_r  <= in_rotation_request;
      s1_yaw_r  <= in_yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      pend_rot_r  <= '0;
      turning_r   <= 1'b0;
      target_r    <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      pend_rot_r  <= pend_rot_nxt;
      turning_r   <= turning_nxt;
      target_r    <= target_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    done_r  <= done_nxt;
    made_r  <= made_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_speed_command = speed_r;
  assign out_done_res      = done_r;
  assign out_rotation_made = made_r;

endmodule
